@@ rtl/core/imh_pkg.sv @@
// Shared types and constants for the indexed min-heap core.
// Depends on nothing; every other file in rtl/core imports it.
package imh_pkg;

  localparam int NODES  = 1024;
  localparam int NODE_W = $clog2(NODES);
  localparam int SLOT_W = $clog2(NODES + 1);
  localparam int KEY_W  = 32;

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_CHANGE  = 2'd1;
  localparam logic [1:0] CMD_EXTRACT = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_PRESENT = 3'd3;
  localparam logic [2:0] ST_ABSENT  = 3'd4;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [NODE_W-1:0] node;
    logic [KEY_W-1:0]  key;
  } in_word_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_out;
    logic [KEY_W-1:0]  key_out;
    logic [SLOT_W-1:0] entries;
    logic [2:0]        status;
  } out_word_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_X_KEY, S_P_KEY,
    S_RISE_RD, S_RISE_KEY, S_RISE_CMP,
    S_SINK_RD, S_SINK_KEY, S_SINK_CMP, S_PUT, S_EMIT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLR, OP_LOAD, OP_ERR, OP_PRES, OP_PRES_K, OP_INS, OP_CHG,
    OP_X_A, OP_X_B, OP_RISE_RD, OP_SINK_RD, OP_KEY_RD, OP_RISE_MV,
    OP_SINK_MV, OP_PUT, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] st;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       clr_done;
    logic       empty;
    logic       full;
    logic       present;
    logic       bad_node;
    logic       absent;
    logic       multi;
    logic       at_root;
    logic       less;
    logic       leaf;
    logic       more;
  } dp_stat_t;

endpackage

@@ rtl/core/imh_dp.sv @@
// Datapath of the indexed min-heap: slot, position and key memories,
// the sift registers and the result register. Depends on imh_pkg.
module imh_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  imh_pkg::dp_cmd_t  dp_cmd,
  input  imh_pkg::in_word_t in_word,
  output imh_pkg::dp_stat_t dp_stat,
  output logic              out_strobe,
  output imh_pkg::out_word_t out_word
);
  import imh_pkg::*;

  logic [NODE_W-1:0] heap_mem [NODES+1];
  logic [SLOT_W-1:0] son_mem  [NODES];
  logic [KEY_W-1:0]  key_mem  [NODES];

  logic [NODE_W-1:0] heap_qa_r, heap_qb_r;
  logic [KEY_W-1:0]  key_qa_r, key_qb_r;
  logic [SLOT_W-1:0] son_q_r;

  logic [SLOT_W-1:0] count_r, count_nxt;
  logic [NODE_W-1:0] clr_r, clr_nxt;
  logic              out_strobe_r, out_strobe_nxt;

  logic [1:0]        cmd_r, cmd_nxt;
  logic [NODE_W-1:0] node_r, node_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [NODE_W-1:0] n_r, n_nxt;
  logic [KEY_W-1:0]  k_r, k_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [NODE_W-1:0] rnode_r, rnode_nxt;
  logic [KEY_W-1:0]  rkey_r, rkey_nxt;
  logic [2:0]        rstat_r, rstat_nxt;
  out_word_t         out_word_r, out_word_nxt;

  logic              heap_re, key_re, son_re;
  logic [SLOT_W-1:0] heap_ra, heap_rb;
  logic [NODE_W-1:0] key_ra, key_rb, son_ra;
  logic              heap_we, key_we, son_we;
  logic [SLOT_W-1:0] heap_wa, son_wd;
  logic [NODE_W-1:0] heap_wd, key_wa, son_wa;
  logic [KEY_W-1:0]  key_wd;

  logic [SLOT_W:0]   child_w;
  logic [SLOT_W-1:0] child;
  logic              has_right, pick_b;
  logic [KEY_W-1:0]  kc;
  logic [NODE_W-1:0] cnode;

  assign child_w   = {slot_r, 1'b0};
  assign child     = child_w[SLOT_W-1:0];
  assign has_right = (child_w + (SLOT_W+1)'(1)) <= {1'b0, count_r};
  // Between equal children the left one wins.
  assign pick_b    = has_right && (key_qb_r < key_qa_r);
  assign kc        = pick_b ? key_qb_r : key_qa_r;
  assign cnode     = pick_b ? heap_qb_r : heap_qa_r;

  assign dp_stat.cmd      = cmd_r;
  assign dp_stat.clr_done = (clr_r == NODE_W'(NODES - 1));
  assign dp_stat.empty    = (count_r == '0);
  assign dp_stat.full     = (count_r >= SLOT_W'(NODES));
  assign dp_stat.present  = (son_q_r != '0);
  assign dp_stat.bad_node = ({1'b0, node_r} >= (NODE_W+1)'(NODES));
  assign dp_stat.absent   = (son_q_r == '0) || (son_q_r > count_r);
  assign dp_stat.multi    = (count_r > SLOT_W'(1));
  assign dp_stat.at_root  = (slot_r <= SLOT_W'(1));
  assign dp_stat.less     = (k_r < key_qa_r);
  assign dp_stat.leaf     = (child_w > {1'b0, count_r});
  assign dp_stat.more     = (k_r > kc);

  always_comb begin
    heap_re = 1'b0; key_re = 1'b0; son_re = 1'b0;
    heap_ra = '0; heap_rb = '0; key_ra = '0; key_rb = '0; son_ra = '0;
    heap_we = 1'b0; key_we = 1'b0; son_we = 1'b0;
    heap_wa = '0; heap_wd = '0; key_wa = '0; key_wd = '0; son_wa = '0; son_wd = '0;
    count_nxt = count_r; clr_nxt = clr_r; out_strobe_nxt = 1'b0;
    cmd_nxt = cmd_r; node_nxt = node_r; key_nxt = key_r;
    n_nxt = n_r; k_nxt = k_r; slot_nxt = slot_r;
    rnode_nxt = rnode_r; rkey_nxt = rkey_r; rstat_nxt = rstat_r;
    out_word_nxt = out_word_r;
    unique case (dp_cmd.op)
      OP_CLR: begin
        son_we = 1'b1; son_wa = clr_r; son_wd = '0;
        clr_nxt = clr_r + NODE_W'(1);
      end
      OP_LOAD: begin
        cmd_nxt = in_word.cmd; node_nxt = in_word.node; key_nxt = in_word.key;
        son_re = 1'b1; son_ra = in_word.node;
        heap_re = 1'b1; heap_ra = SLOT_W'(1); heap_rb = count_r;
      end
      OP_ERR: begin
        rnode_nxt = (dp_cmd.st == ST_EMPTY) ? '0 : node_r;
        rkey_nxt = '0; rstat_nxt = dp_cmd.st;
      end
      OP_PRES: begin
        key_re = 1'b1; key_ra = node_r;
        rnode_nxt = node_r; rstat_nxt = ST_PRESENT;
      end
      OP_PRES_K: rkey_nxt = key_qa_r;
      OP_INS: begin
        key_we = 1'b1; key_wa = node_r; key_wd = key_r;
        count_nxt = count_r + SLOT_W'(1);
        n_nxt = node_r; k_nxt = key_r; slot_nxt = count_r + SLOT_W'(1);
        rnode_nxt = node_r; rkey_nxt = key_r; rstat_nxt = ST_OK;
      end
      OP_CHG: begin
        key_we = 1'b1; key_wa = node_r; key_wd = key_r;
        n_nxt = node_r; k_nxt = key_r; slot_nxt = son_q_r;
        rnode_nxt = node_r; rkey_nxt = key_r; rstat_nxt = ST_OK;
      end
      OP_X_A: begin
        // The root leaves; the last slot's node will sink from the root.
        rnode_nxt = heap_qa_r; rstat_nxt = ST_OK;
        key_re = 1'b1; key_ra = heap_qa_r; key_rb = heap_qb_r;
        son_we = 1'b1; son_wa = heap_qa_r; son_wd = '0;
        n_nxt = heap_qb_r; slot_nxt = SLOT_W'(1);
      end
      OP_X_B: begin
        rkey_nxt = key_qa_r; k_nxt = key_qb_r;
        count_nxt = count_r - SLOT_W'(1);
      end
      OP_RISE_RD: begin
        heap_re = 1'b1; heap_ra = slot_r >> 1; heap_rb = slot_r >> 1;
      end
      OP_SINK_RD: begin
        heap_re = 1'b1; heap_ra = child;
        heap_rb = has_right ? child + SLOT_W'(1) : child;
      end
      OP_KEY_RD: begin
        key_re = 1'b1; key_ra = heap_qa_r; key_rb = heap_qb_r;
      end
      OP_RISE_MV: begin
        heap_we = 1'b1; heap_wa = slot_r; heap_wd = heap_qa_r;
        son_we = 1'b1; son_wa = heap_qa_r; son_wd = slot_r;
        slot_nxt = slot_r >> 1;
      end
      OP_SINK_MV: begin
        heap_we = 1'b1; heap_wa = slot_r; heap_wd = cnode;
        son_we = 1'b1; son_wa = cnode; son_wd = slot_r;
        slot_nxt = child + SLOT_W'(pick_b);
      end
      OP_PUT: begin
        heap_we = 1'b1; heap_wa = slot_r; heap_wd = n_r;
        son_we = 1'b1; son_wa = n_r; son_wd = slot_r;
      end
      OP_EMIT: begin
        out_strobe_nxt = 1'b1;
        out_word_nxt.node_out = rnode_r;
        out_word_nxt.key_out  = rkey_r;
        out_word_nxt.entries  = count_r;
        out_word_nxt.status   = rstat_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      clr_r <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      clr_r <= clr_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; node_r <= node_nxt; key_r <= key_nxt;
    n_r <= n_nxt; k_r <= k_nxt; slot_r <= slot_nxt;
    rnode_r <= rnode_nxt; rkey_r <= rkey_nxt; rstat_r <= rstat_nxt;
    out_word_r <= out_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (heap_we) heap_mem[heap_wa] <= heap_wd;
    if (heap_re) begin
      heap_qa_r <= heap_mem[heap_ra];
      heap_qb_r <= heap_mem[heap_rb];
    end
  end

  always_ff @(posedge clk) begin
    if (son_we) son_mem[son_wa] <= son_wd;
    if (son_re) son_q_r <= son_mem[son_ra];
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_wa] <= key_wd;
    if (key_re) begin
      key_qa_r <= key_mem[key_ra];
      key_qb_r <= key_mem[key_rb];
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule

@@ rtl/core/imh_ctrl.sv @@
// Controller state machine of the indexed min-heap: sequences the
// datapath through checks, sift-up and sift-down. Depends on imh_pkg.
module imh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  imh_pkg::dp_stat_t dp_stat,
  output imh_pkg::dp_cmd_t  dp_cmd,
  output logic              busy
);
  import imh_pkg::*;

  state_t state_r, state_nxt;
  logic   after_rise;

  // A changed key sinks after it has risen; an inserted one is placed.
  assign after_rise = (dp_stat.cmd == CMD_CHANGE);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:    if (dp_stat.clr_done) state_nxt = S_IDLE;
      S_IDLE:     if (start) state_nxt = S_DECODE;
      S_DECODE: begin
        case (dp_stat.cmd)
          CMD_EXTRACT: state_nxt = dp_stat.empty ? S_EMIT : S_X_KEY;
          CMD_INSERT: begin
            if (dp_stat.bad_node) state_nxt = S_EMIT;
            else if (dp_stat.present) state_nxt = S_P_KEY;
            else if (dp_stat.full) state_nxt = S_EMIT;
            else state_nxt = S_RISE_RD;
          end
          CMD_CHANGE:
            state_nxt = (dp_stat.bad_node || dp_stat.absent) ? S_EMIT : S_RISE_RD;
          default:    state_nxt = S_EMIT;
        endcase
      end
      S_X_KEY:    state_nxt = dp_stat.multi ? S_SINK_RD : S_EMIT;
      S_P_KEY:    state_nxt = S_EMIT;
      S_RISE_RD: begin
        if (dp_stat.at_root) state_nxt = after_rise ? S_SINK_RD : S_PUT;
        else state_nxt = S_RISE_KEY;
      end
      S_RISE_KEY: state_nxt = S_RISE_CMP;
      S_RISE_CMP: begin
        if (dp_stat.less) state_nxt = S_RISE_RD;
        else state_nxt = after_rise ? S_SINK_RD : S_PUT;
      end
      S_SINK_RD:  state_nxt = dp_stat.leaf ? S_PUT : S_SINK_KEY;
      S_SINK_KEY: state_nxt = S_SINK_CMP;
      S_SINK_CMP: state_nxt = dp_stat.more ? S_SINK_RD : S_PUT;
      S_PUT:      state_nxt = S_EMIT;
      S_EMIT:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    dp_cmd.op = OP_NONE;
    dp_cmd.st = ST_OK;
    busy = (state_r != S_IDLE);
    unique case (state_r)
      S_CLEAR: dp_cmd.op = OP_CLR;
      S_IDLE:  if (start) dp_cmd.op = OP_LOAD;
      S_DECODE: begin
        case (dp_stat.cmd)
          CMD_EXTRACT: begin
            if (dp_stat.empty) begin
              dp_cmd.op = OP_ERR; dp_cmd.st = ST_EMPTY;
            end else dp_cmd.op = OP_X_A;
          end
          CMD_INSERT: begin
            if (dp_stat.bad_node) begin
              dp_cmd.op = OP_ERR; dp_cmd.st = ST_ABSENT;
            end else if (dp_stat.present) dp_cmd.op = OP_PRES;
            else if (dp_stat.full) begin
              dp_cmd.op = OP_ERR; dp_cmd.st = ST_FULL;
            end else dp_cmd.op = OP_INS;
          end
          CMD_CHANGE: begin
            if (dp_stat.bad_node || dp_stat.absent) begin
              dp_cmd.op = OP_ERR; dp_cmd.st = ST_ABSENT;
            end else dp_cmd.op = OP_CHG;
          end
          default: begin
            dp_cmd.op = OP_ERR; dp_cmd.st = ST_OK;
          end
        endcase
      end
      S_X_KEY:    dp_cmd.op = OP_X_B;
      S_P_KEY:    dp_cmd.op = OP_PRES_K;
      S_RISE_RD:  if (!dp_stat.at_root) dp_cmd.op = OP_RISE_RD;
      S_RISE_KEY: dp_cmd.op = OP_KEY_RD;
      S_RISE_CMP: if (dp_stat.less) dp_cmd.op = OP_RISE_MV;
      S_SINK_RD:  if (!dp_stat.leaf) dp_cmd.op = OP_SINK_RD;
      S_SINK_KEY: dp_cmd.op = OP_KEY_RD;
      S_SINK_CMP: if (dp_stat.more) dp_cmd.op = OP_SINK_MV;
      S_PUT:      dp_cmd.op = OP_PUT;
      S_EMIT:     dp_cmd.op = OP_EMIT;
      default:    dp_cmd.op = OP_NONE;
    endcase
  end

endmodule

@@ rtl/core/indexed_min_heap_core.sv @@
// Indexed binary min-heap: node numbers ordered by key, with a position map.
// One command word is taken when start is high and busy is low; its single
// result word appears on out_word for one cycle with out_strobe, and cannot
// be held off. After reset the position map is cleared one entry a cycle, so
// busy stays high until all 1024 entries are cleared. A refused command skips
// the sift loop; one that changes the heap runs it, one heap level at a time.
// The pace is set by the registered reads of the slot and key memories: one
// level needs a slot read, a key read and a compare-and-move. The longest
// command is a key change that rises ten levels to the root and is then
// compared with its children. A new word may be taken in the cycle in which
// the previous result is out.
module indexed_min_heap_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  imh_pkg::in_word_t  in_word,
  output logic               out_strobe,
  output imh_pkg::out_word_t out_word
);
  import imh_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  imh_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .dp_stat (dp_stat),
    .dp_cmd  (dp_cmd),
    .busy    (busy)
  );

  imh_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .dp_cmd     (dp_cmd),
    .in_word    (in_word),
    .dp_stat    (dp_stat),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule

@@ dv/indexed_min_heap_checker.sv @@
// Checker for the indexed min-heap core: watches command and result words,
// keeps its own heap image and compares every result field. Needs imh_pkg.
module indexed_min_heap_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  imh_pkg::in_word_t  in_word,
  input  logic               out_strobe,
  input  imh_pkg::out_word_t out_word,
  output int                 fail_count,
  output int                 pending
);
  import imh_pkg::*;

  logic [NODE_W-1:0] slot_node [1:NODES];
  logic [SLOT_W-1:0] node_slot [NODES];
  logic [KEY_W-1:0]  key_of [NODES];
  int                count;
  out_word_t         expected_words [$];

  assign pending = expected_words.size();

  function automatic void place(int s, logic [NODE_W-1:0] n);
    slot_node[s] = n;
    node_slot[n] = SLOT_W'(s);
  endfunction

  function automatic int sift_up(int s);
    logic [NODE_W-1:0] n;
    n = slot_node[s];
    while (s > 1 && key_of[n] < key_of[slot_node[s/2]]) begin
      place(s, slot_node[s/2]);
      s = s / 2;
    end
    place(s, n);
    return s;
  endfunction

  function automatic void sift_down(int s);
    logic [NODE_W-1:0] n;
    int c;
    n = slot_node[s];
    forever begin
      c = 2 * s;
      if (c > count) break;
      if (c + 1 <= count && key_of[slot_node[c+1]] < key_of[slot_node[c]]) c = c + 1;
      if (key_of[n] > key_of[slot_node[c]]) begin
        place(s, slot_node[c]);
        s = c;
      end else break;
    end
    place(s, n);
  endfunction

  function automatic out_word_t apply_command(in_word_t w);
    out_word_t r;
    int s;
    r = '0;
    r.node_out = w.node;
    r.status = ST_OK;
    if (w.cmd == CMD_EXTRACT) begin
      if (count == 0) begin
        r.node_out = '0;
        r.status = ST_EMPTY;
      end else begin
        r.node_out = slot_node[1];
        r.key_out = key_of[slot_node[1]];
        node_slot[slot_node[1]] = '0;
        if (count > 1) begin
          place(1, slot_node[count]);
          count--;
          sift_down(1);
        end else count = 0;
      end
    end else if (w.cmd == CMD_INSERT) begin
      if (node_slot[w.node] != 0) begin
        r.key_out = key_of[w.node];
        r.status = ST_PRESENT;
      end else if (count >= NODES) begin
        r.status = ST_FULL;
      end else begin
        key_of[w.node] = w.key;
        count++;
        place(count, w.node);
        s = sift_up(count);
        r.key_out = w.key;
      end
    end else if (w.cmd == CMD_CHANGE) begin
      s = node_slot[w.node];
      if (s == 0 || s > count) r.status = ST_ABSENT;
      else begin
        key_of[w.node] = w.key;
        s = sift_up(s);
        sift_down(s);
        r.key_out = w.key;
      end
    end
    r.entries = SLOT_W'(count);
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      fail_count <= 0;
      count = 0;
      for (int i = 0; i < NODES; i++) node_slot[i] = '0;
      expected_words.delete();
    end else begin
      if (out_strobe) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word %p", $time, out_word);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_words.pop_front();
          if (out_word.node_out !== e.node_out || out_word.key_out !== e.key_out ||
              out_word.entries !== e.entries || out_word.status !== e.status) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, out_word);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) expected_words.push_back(apply_command(in_word));
    end
  end
endmodule

@@ dv/indexed_min_heap_core_test.sv @@
// Top of the min-heap core testbench: clock, reset and command stimulus.
// Depends on imh_pkg, the core and indexed_min_heap_checker.
module indexed_min_heap_core_test;
  import imh_pkg::*;

  // Command code with no operation behind it.
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int         FILL      = 256;

  logic      clk, rst_n, start, busy, out_strobe;
  in_word_t  in_word;
  out_word_t out_word;
  int        fail_count, pending;
  bit        present [NODES];
  int        live;

  indexed_min_heap_core uut (.*);
  indexed_min_heap_checker chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #400000000;
    $display("== FAIL ==");
    $finish;
  end

  // Sends one command word after an optional random gap; returns once it has been taken.
  task automatic send(logic [1:0] c, logic [NODE_W-1:0] n, logic [KEY_W-1:0] k,
                      bit allow_gap = 1);
    int gap;
    gap = allow_gap && $urandom_range(3) == 0 ? int'($urandom_range(19)) : 0;
    repeat (gap) @(posedge clk);
    start   <= 1'b1;
    in_word <= '{cmd: c, node: n, key: k};
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    if (c == CMD_INSERT && !present[n]) begin present[n] = 1; live++; end
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [NODE_W-1:0] pick_present();
    int n;
    n = $urandom_range(NODES - 1);
    repeat (2000) begin
      if (present[n]) return NODE_W'(n);
      n = (n + 1) % NODES;
    end
    return NODE_W'(n);
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    return $urandom_range(1) ? KEY_W'($urandom_range(7)) : KEY_W'($urandom);
  endfunction

  initial begin
    logic [NODE_W-1:0] n;
    int r;
    start = 0; in_word = '0; rst_n = 0; live = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: empty extract, unused code, absent change, ties and extremes.
    send(CMD_EXTRACT, 10'd5, 32'hFFFF_FFFF);
    send(CMD_SPARE, 10'h3FF, 32'hFFFF_FFFF);
    send(CMD_CHANGE, 10'd7, 32'd1);
    send(CMD_INSERT, 10'h3FF, 32'hFFFF_FFFF);
    send(CMD_INSERT, 10'd0, 32'd0);
    send(CMD_INSERT, 10'd1, 32'd0);
    send(CMD_INSERT, 10'd2, 32'd0);
    send(CMD_INSERT, 10'd3, 32'h8000_0000);
    send(CMD_INSERT, 10'd0, 32'd9);
    send(CMD_CHANGE, 10'd0, 32'hFFFF_FFFF);
    send(CMD_CHANGE, 10'd3, 32'd0);
    send(CMD_CHANGE, 10'h3FF, 32'h5555_AAAA);
    repeat (7) send(CMD_EXTRACT, '0, '0);
    for (int i = 0; i < NODES; i++) present[i] = 0;
    live = 0;
    drain();
    // Build a deep heap, probe a present node, then empty it.
    for (int i = 0; i < FILL; i++) send(CMD_INSERT, NODE_W'(i), KEY_W'($urandom_range(15)), 0);
    send(CMD_INSERT, 10'd3, 32'd1);
    drain();
    for (int i = 0; i < FILL; i++) present[i] = 1;
    live = FILL;
    send(CMD_EXTRACT, '0, '0);
    send(CMD_INSERT, 10'd100, 32'd2);
    drain();
    for (int i = 0; i <= FILL; i++) send(CMD_EXTRACT, '0, '0, 0);
    for (int i = 0; i < NODES; i++) present[i] = 0;
    live = 0;
    drain();
    // Random mix, mostly well-formed work on present nodes.
    for (int i = 0; i < 360; i++) begin
      r = $urandom_range(99);
      if (i == 180) drain();
      if (r < 40 || live == 0) begin
        n = $urandom_range(1) ? NODE_W'($urandom_range(63)) : NODE_W'($urandom);
        send(CMD_INSERT, n, rand_key());
      end else if (r < 65) begin
        send(CMD_CHANGE, r < 62 ? pick_present() : NODE_W'($urandom), rand_key());
      end else if (r < 97) begin
        send(CMD_EXTRACT, NODE_W'($urandom), $urandom);
        live = live - 1;
      end else send(CMD_SPARE, NODE_W'($urandom), $urandom);
      if (live <= 0) begin
        drain();
        for (int j = 0; j < NODES; j++) present[j] = 0;
        live = 0;
      end
    end
    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
